// ----- rtl/itoa_pkg.sv -----
// itoa_pkg: shared constants, register map, state types and the digit-to-character function
// for the integer to ascii formatter; no dependencies
package itoa_pkg;

	// field widths fixed by the interface
	localparam int NUM_W         = 64;
	localparam int RADIX_W       = 6;
	localparam int FW_W          = 7;
	localparam int CHAR_W        = 8;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 32;
	localparam int MAX_FIELD_DEF = 64;

	// serial divider: bits of the dividend consumed per cycle
	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = NUM_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// radix limits and reset values
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [FW_W-1:0]    FW_RESET    = 7'd20;

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

	// register map, word index
	typedef enum logic [2:0] {
		REG_RADIX,
		REG_FIELD_WIDTH,
		REG_IS_SIGNED,
		REG_FORCE_SIGN,
		REG_UPPER_CASE,
		REG_ZERO_EMPTY,
		REG_FILL_MODE,
		REG_NULL_TERM
	} reg_idx_t;

	// top level phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DIVIDE,
		PH_LOAD,
		PH_EMIT
	} phase_t;

	// emitter section
	typedef enum logic [2:0] {
		SEC_IDLE,
		SEC_SIGN,
		SEC_FILL,
		SEC_DIGIT,
		SEC_TERM
	} sec_t;

	// per-item format handed to the emitter
	typedef struct packed {
		logic sign_on;
		logic neg;
		logic zero_fill;
		logic term;
		logic upper;
	} emit_cfg_t;

	// digit value to ascii, digits above 35 wrap modulo 36
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
		input logic upper);
		logic [RADIX_W-1:0] m;
		logic [CHAR_W-1:0] base;
		m = (d >= RADIX_MAX) ? RADIX_W'(d - RADIX_MAX) : d;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (m < 6'd10) begin
			digit_char = CHAR_W'(CH_ZERO + {2'b00, m});
		end else begin
			digit_char = CHAR_W'(base + {2'b00, m} - 8'd10);
		end
	endfunction

endpackage

// ----- rtl/itoa_div.sv -----
// itoa_div: digit-serial divider, one remainder digit per run started by go, eight dividend bits
// per cycle through a narrow compare-subtract chain; depends on itoa_pkg
module itoa_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [itoa_pkg::NUM_W-1:0]     value,
	input  logic                           go,
	input  logic [itoa_pkg::RADIX_W-1:0]   base,
	output logic [itoa_pkg::NUM_W-1:0]     val,
	output logic [itoa_pkg::RADIX_W-1:0]   digit,
	output logic                           busy,
	output logic                           done
);
	import itoa_pkg::*;

	logic [NUM_W-1:0]     val_q;
	logic [RADIX_W-1:0]   acc_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [RADIX_W-1:0]   acc_nx;
	logic [DIV_BITS-1:0]  qbits;
	logic                 last_step;

	// one step of restoring division: shift in eight dividend bits
	always_comb begin
		logic [RADIX_W:0] t;
		acc_nx = acc_q;
		qbits = '0;
		t = '0;
		for (int j = 0; j < DIV_BITS; j++) begin
			t = {acc_nx, val_q[NUM_W-1-j]};
			if (t >= {1'b0, base}) begin
				qbits[DIV_BITS-1-j] = 1'b1;
				acc_nx = RADIX_W'(t - {1'b0, base});
			end else begin
				acc_nx = t[RADIX_W-1:0];
			end
		end
	end

	assign last_step = (step_q == DIV_CNT_W'(DIV_STEPS - 1));

	// dividend shifts out at the top while quotient bits fill in at the bottom
	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= value;
		end else if (busy_q) begin
			val_q <= {val_q[NUM_W-DIV_BITS-1:0], qbits};
		end
		if (go) begin
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nx;
		end
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last_step;
			if (go) begin
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= DIV_CNT_W'(step_q + 1'b1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign val   = val_q;
	assign digit = acc_q;
	assign busy  = busy_q;
	assign done  = done_q;

endmodule

// ----- rtl/itoa_store.sv -----
// itoa_store: digit memory, one write port and one registered read port
// depends on itoa_pkg for the digit width
module itoa_store #(
	parameter int DEPTH = itoa_pkg::MAX_FIELD_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [itoa_pkg::RADIX_W-1:0]   wdata,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [itoa_pkg::RADIX_W-1:0]   rdata
);
	import itoa_pkg::*;

	logic [RADIX_W-1:0] mem [DEPTH];
	logic [RADIX_W-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/itoa_emit.sv -----
// itoa_emit: character sequencer (sign, fill, digits from memory, terminator) with output register
// depends on itoa_pkg
module itoa_emit #(
	parameter int MAX_FIELD = itoa_pkg::MAX_FIELD_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  itoa_pkg::emit_cfg_t                cfg,
	input  logic [$clog2(MAX_FIELD+1)-1:0]     fill_cnt,
	input  logic [$clog2(MAX_FIELD+1)-1:0]     dig_cnt,
	output logic [$clog2(MAX_FIELD)-1:0]       rd_addr,
	input  logic [itoa_pkg::RADIX_W-1:0]       rd_data,
	output logic                               busy,
	output logic [itoa_pkg::CHAR_W-1:0]        char_out,
	output logic                               last_char,
	output logic                               out_valid,
	input  logic                               out_ready
);
	import itoa_pkg::*;

	localparam int CW = $clog2(MAX_FIELD + 1);
	localparam int AW = $clog2(MAX_FIELD);

	sec_t              sec_q, sec_d;
	logic [CW-1:0]     fill_q, fill_d;
	logic [CW-1:0]     dig_q, dig_d;
	logic [AW-1:0]     dp_q, dp_d;
	emit_cfg_t         cfg_q, cfg_d;
	logic              ovalid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              load;
	logic [CHAR_W-1:0] ch;
	logic [CW-1:0]     dig_m1;

	assign load   = (sec_q != SEC_IDLE) && (!ovalid_q || out_ready);
	assign dig_m1 = CW'(dig_cnt - 1'b1);

	// section sequencing and character select
	always_comb begin
		sec_d  = sec_q;
		fill_d = fill_q;
		dig_d  = dig_q;
		dp_d   = dp_q;
		cfg_d  = cfg_q;
		ch     = CH_NUL;
		unique case (sec_q)
			SEC_IDLE: begin
				if (start) begin
					cfg_d  = cfg;
					fill_d = fill_cnt;
					dig_d  = dig_cnt;
					dp_d   = dig_m1[AW-1:0];
					if (cfg.sign_on) begin
						sec_d = SEC_SIGN;
					end else if (fill_cnt != '0) begin
						sec_d = SEC_FILL;
					end else if (dig_cnt != '0) begin
						sec_d = SEC_DIGIT;
					end else if (cfg.term) begin
						sec_d = SEC_TERM;
					end
				end
			end
			SEC_SIGN: begin
				ch = cfg_q.neg ? CH_MINUS : CH_PLUS;
				if (load) begin
					if (fill_q != '0) begin
						sec_d = SEC_FILL;
					end else if (dig_q != '0) begin
						sec_d = SEC_DIGIT;
					end else if (cfg_q.term) begin
						sec_d = SEC_TERM;
					end else begin
						sec_d = SEC_IDLE;
					end
				end
			end
			SEC_FILL: begin
				ch = cfg_q.zero_fill ? CH_ZERO : CH_SPACE;
				if (load) begin
					fill_d = CW'(fill_q - 1'b1);
					if (fill_q != CW'(1)) begin
						sec_d = SEC_FILL;
					end else if (dig_q != '0) begin
						sec_d = SEC_DIGIT;
					end else if (cfg_q.term) begin
						sec_d = SEC_TERM;
					end else begin
						sec_d = SEC_IDLE;
					end
				end
			end
			SEC_DIGIT: begin
				ch = digit_char(rd_data, cfg_q.upper);
				if (load) begin
					dig_d = CW'(dig_q - 1'b1);
					dp_d  = AW'(dp_q - 1'b1);
					if (dig_q != CW'(1)) begin
						sec_d = SEC_DIGIT;
					end else if (cfg_q.term) begin
						sec_d = SEC_TERM;
					end else begin
						sec_d = SEC_IDLE;
					end
				end
			end
			SEC_TERM: begin
				ch = CH_NUL;
				if (load) begin
					sec_d = SEC_IDLE;
				end
			end
			default: begin
				sec_d = SEC_IDLE;
			end
		endcase
	end

	// read address follows the next pointer so read data matches dp_q
	assign rd_addr = dp_d;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= SEC_IDLE;
		end else begin
			sec_q <= sec_d;
		end
	end

	always_ff @(posedge clk) begin
		fill_q <= fill_d;
		dig_q  <= dig_d;
		dp_q   <= dp_d;
		cfg_q  <= cfg_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
			last_q   <= (sec_d == SEC_IDLE);
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= ch;
		end
	end

	assign busy      = (sec_q != SEC_IDLE);
	assign char_out  = char_q;
	assign last_char = last_q;
	assign out_valid = ovalid_q;

endmodule

// ----- rtl/integer_to_ascii_formatter_core.sv -----
// integer_to_ascii_formatter_core: top level, config registers, digit generation control
// digits come one at a time from the serial divider (8 dividend bits per cycle), then the
// emitter runs; characters leave one per cycle while out_ready is high; one item at a time
// reset: config registers return to their reset values and all control clears; the digit
// memory is not cleared, as every entry read was written for the same item
module integer_to_ascii_formatter_core #(
	parameter int MAX_FIELD = itoa_pkg::MAX_FIELD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [itoa_pkg::ADDR_W-1:0]    paddr,
	input  logic [itoa_pkg::DATA_W-1:0]    pwdata,
	output logic [itoa_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic [itoa_pkg::NUM_W-1:0]     number,
	input  logic                           in_valid,
	output logic                           in_ready,
	output logic [itoa_pkg::CHAR_W-1:0]    char_out,
	output logic                           last_char,
	output logic                           out_valid,
	input  logic                           out_ready
);
	import itoa_pkg::*;

	localparam int CW = $clog2(MAX_FIELD + 1);
	localparam int AW = $clog2(MAX_FIELD);

	// configuration registers
	logic [RADIX_W-1:0] radix_q;
	logic [FW_W-1:0]    fw_q;
	logic               is_signed_q;
	logic               force_sign_q;
	logic               upper_q;
	logic               zero_empty_q;
	logic [1:0]         fill_mode_q;
	logic               null_term_q;
	logic               cfg_wr;
	reg_idx_t           reg_idx;

	phase_t             ph_q, ph_d;
	logic               accept;
	logic               neg, sign_on;
	logic [NUM_W-1:0]   mag;
	logic [1:0]         ovh;
	logic [FW_W-1:0]    width7, area7;
	logic [RADIX_W-1:0] base;
	logic               neg_q, sign_q;
	logic [CW-1:0]      area_q, cnt_q;

	logic [NUM_W-1:0]   div_val;
	logic [RADIX_W-1:0] div_digit;
	logic               div_busy, div_done, div_go;
	logic               finish, fixup;
	logic               mem_we;
	logic [RADIX_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [RADIX_W-1:0] mem_rdata;
	logic               emit_start, emit_busy;
	emit_cfg_t          emit_cfg;
	logic [CW-1:0]      fill_cnt;

	// register write decode
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= RADIX_RESET;
			fw_q         <= FW_RESET;
			is_signed_q  <= 1'b0;
			force_sign_q <= 1'b0;
			upper_q      <= 1'b0;
			zero_empty_q <= 1'b0;
			fill_mode_q  <= 2'b00;
			null_term_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RADIX:       radix_q      <= pwdata[RADIX_W-1:0];
				REG_FIELD_WIDTH: fw_q         <= pwdata[FW_W-1:0];
				REG_IS_SIGNED:   is_signed_q  <= pwdata[0];
				REG_FORCE_SIGN:  force_sign_q <= pwdata[0];
				REG_UPPER_CASE:  upper_q      <= pwdata[0];
				REG_ZERO_EMPTY:  zero_empty_q <= pwdata[0];
				REG_FILL_MODE:   fill_mode_q  <= pwdata[1:0];
				REG_NULL_TERM:   null_term_q  <= pwdata[0];
			endcase
		end
	end

	// register read mux
	always_comb begin
		unique case (reg_idx)
			REG_RADIX:       prdata = DATA_W'(radix_q);
			REG_FIELD_WIDTH: prdata = DATA_W'(fw_q);
			REG_IS_SIGNED:   prdata = DATA_W'(is_signed_q);
			REG_FORCE_SIGN:  prdata = DATA_W'(force_sign_q);
			REG_UPPER_CASE:  prdata = DATA_W'(upper_q);
			REG_ZERO_EMPTY:  prdata = DATA_W'(zero_empty_q);
			REG_FILL_MODE:   prdata = DATA_W'(fill_mode_q);
			REG_NULL_TERM:   prdata = DATA_W'(null_term_q);
		endcase
	end

	// clamp radix into the supported range
	assign base = (radix_q < RADIX_MIN) ? RADIX_MIN :
		((radix_q > RADIX_MAX) ? RADIX_MAX : radix_q);

	// sign, magnitude and digit area of the incoming beat
	assign accept  = in_valid && in_ready;
	assign neg     = is_signed_q && number[NUM_W-1];
	assign mag     = neg ? NUM_W'(~number + 1'b1) : number;
	assign sign_on = force_sign_q || neg;
	assign ovh     = {1'b0, sign_on} + {1'b0, null_term_q};
	assign width7  = (fw_q > FW_W'(MAX_FIELD)) ? FW_W'(MAX_FIELD) : fw_q;
	assign area7   = (width7 > {{(FW_W-2){1'b0}}, ovh}) ?
		FW_W'(width7 - {{(FW_W-2){1'b0}}, ovh}) : '0;

	// digit loop: stop at zero quotient or a full digit area
	assign finish = (div_val == '0) || (cnt_q == area_q);
	assign div_go = (ph_q == PH_DIVIDE) && !div_busy && !div_done && !finish;
	assign fixup  = (ph_q == PH_DIVIDE) && !div_busy && !div_done && finish &&
		(cnt_q == '0) && !zero_empty_q && (area_q != '0);

	assign mem_we    = div_done || fixup;
	assign mem_wdata = div_done ? div_digit : '0;

	// phase control
	always_comb begin
		ph_d = ph_q;
		emit_start = 1'b0;
		unique case (ph_q)
			PH_IDLE: begin
				if (accept) begin
					ph_d = PH_DIVIDE;
				end
			end
			PH_DIVIDE: begin
				if (!div_busy && !div_done && finish) begin
					ph_d = PH_LOAD;
				end
			end
			PH_LOAD: begin
				emit_start = 1'b1;
				ph_d = PH_EMIT;
			end
			PH_EMIT: begin
				if (!emit_busy) begin
					ph_d = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			cnt_q <= '0;
		end else begin
			ph_q <= ph_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (div_done) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (fixup) begin
				cnt_q <= CW'(1);
			end
		end
	end

	// per-item format
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= neg;
			sign_q <= sign_on;
			area_q <= CW'(area7);
		end
	end

	assign in_ready = (ph_q == PH_IDLE);

	assign emit_cfg.sign_on   = sign_q;
	assign emit_cfg.neg       = neg_q;
	assign emit_cfg.zero_fill = fill_mode_q[1];
	assign emit_cfg.term      = null_term_q;
	assign emit_cfg.upper     = upper_q;
	assign fill_cnt = (fill_mode_q != 2'b00) ? CW'(area_q - cnt_q) : '0;

	itoa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.value  (mag),
		.go     (div_go),
		.base   (base),
		.val    (div_val),
		.digit  (div_digit),
		.busy   (div_busy),
		.done   (div_done)
	);

	itoa_store #(
		.DEPTH (MAX_FIELD)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	itoa_emit #(
		.MAX_FIELD (MAX_FIELD)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (emit_start),
		.cfg       (emit_cfg),
		.fill_cnt  (fill_cnt),
		.dig_cnt   (cnt_q),
		.rd_addr   (mem_raddr),
		.rd_data   (mem_rdata),
		.busy      (emit_busy),
		.char_out  (char_out),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule
